// ===== design/amo_pkg.sv =====
// Shared types and constants for the atomic memory operation unit.
// Used by every module of the block; no dependencies.
package amo_pkg;

  // Major opcodes (instruction bits 6..2)
  localparam logic [4:0] OPC_AMO      = 5'b01011;
  localparam logic [4:0] OPC_MISC_MEM = 5'b00011;

  // funct3 codes
  localparam logic [2:0] F3_WORD    = 3'd2;
  localparam logic [2:0] F3_FENCE   = 3'd0;
  localparam logic [2:0] F3_FENCE_I = 3'd1;

  // AMO funct5 codes
  localparam logic [4:0] F5_LR   = 5'b00010;
  localparam logic [4:0] F5_SC   = 5'b00011;
  localparam logic [4:0] F5_SWAP = 5'b00001;
  localparam logic [4:0] F5_ADD  = 5'b00000;
  localparam logic [4:0] F5_XOR  = 5'b00100;
  localparam logic [4:0] F5_AND  = 5'b01100;
  localparam logic [4:0] F5_OR   = 5'b01000;
  localparam logic [4:0] F5_MIN  = 5'b10000;
  localparam logic [4:0] F5_MAX  = 5'b10100;
  localparam logic [4:0] F5_MINU = 5'b11000;
  localparam logic [4:0] F5_MAXU = 5'b11100;

  // Cause codes
  localparam logic [2:0] CAUSE_OK        = 3'd0;
  localparam logic [2:0] CAUSE_ILLEGAL   = 3'd1;
  localparam logic [2:0] CAUSE_LOAD_MIS  = 3'd2;
  localparam logic [2:0] CAUSE_STORE_MIS = 3'd3;
  localparam logic [2:0] CAUSE_HALT      = 3'd4;

  // Operation class decided by the front end
  localparam logic [1:0] KIND_NOP = 2'd0;
  localparam logic [1:0] KIND_LR  = 2'd1;
  localparam logic [1:0] KIND_SC  = 2'd2;
  localparam logic [1:0] KIND_RMW = 2'd3;

  // Queue sizing (decoupling queue and output buffer)
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Classified instruction handed from front to back
  typedef struct packed {
    logic [2:0]  cause;
    logic [1:0]  kind;
    logic [4:0]  funct5;
    logic [4:0]  rd;
    logic [31:0] addr;
    logic [31:0] opnd;
    logic [31:0] mem;
  } amo_item_t;

  // Finished result
  typedef struct packed {
    logic [2:0]  cause;
    logic        dest_write;
    logic [4:0]  dest_index;
    logic [31:0] dest_data;
    logic        store_enable;
    logic [31:0] store_address;
    logic [31:0] store_data;
  } amo_result_t;

endpackage

// ===== design/amo_front.sv =====
// Front end: decodes and classifies one instruction into an amo_item_t.
// Depends on amo_pkg.
module amo_front import amo_pkg::*; (
  input  logic [31:0] instruction,
  input  logic [31:0] base_value,
  input  logic [31:0] operand_value,
  input  logic [31:0] memory_word,
  output amo_item_t   item
);

  logic [4:0] major;
  logic [2:0] f3;
  logic [4:0] f5;
  logic [4:0] rs2;

  assign major = instruction[6:2];
  assign f3    = instruction[14:12];
  assign f5    = instruction[31:27];
  assign rs2   = instruction[24:20];

  // Cause and class; state-independent checks all happen here
  always_comb begin
    item.cause  = CAUSE_ILLEGAL;
    item.kind   = KIND_NOP;
    item.funct5 = f5;
    item.rd     = instruction[11:7];
    item.addr   = base_value;
    item.opnd   = operand_value;
    item.mem    = memory_word;
    unique case (major)
      OPC_AMO: begin
        if (f3 != F3_WORD) begin
          item.cause = CAUSE_ILLEGAL;
        end else if (base_value[1:0] != 2'b00) begin
          item.cause = (f5 == F5_LR) ? CAUSE_LOAD_MIS : CAUSE_STORE_MIS;
        end else begin
          unique case (f5) inside
            F5_LR: begin
              if (rs2 != 5'd0) begin
                item.cause = CAUSE_ILLEGAL;
              end else begin
                item.cause = CAUSE_OK;
                item.kind  = KIND_LR;
              end
            end
            F5_SC: begin
              item.cause = CAUSE_OK;
              item.kind  = KIND_SC;
            end
            F5_SWAP, F5_ADD, F5_XOR, F5_AND, F5_OR,
            F5_MIN, F5_MAX, F5_MINU, F5_MAXU: begin
              item.cause = CAUSE_OK;
              item.kind  = KIND_RMW;
            end
            default: item.cause = CAUSE_ILLEGAL;
          endcase
        end
      end
      OPC_MISC_MEM: begin
        unique case (f3)
          F3_FENCE:   item.cause = CAUSE_OK;
          F3_FENCE_I: item.cause = CAUSE_HALT;
          default:    item.cause = CAUSE_ILLEGAL;
        endcase
      end
      default: item.cause = CAUSE_HALT;
    endcase
  end

endmodule

// ===== design/amo_queue.sv =====
// Short FIFO of classified instructions between front and back end.
// Depends on amo_pkg.
module amo_queue import amo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  amo_item_t push_item,
  output logic      empty,
  input  logic      pop,
  output amo_item_t pop_item
);

  amo_item_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign full     = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/amo_back.sv =====
// Back end: holds the LR/SC reservation, executes AMOs and buffers results.
// Depends on amo_pkg.
module amo_back import amo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  amo_item_t   item,
  output logic        item_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output amo_result_t result
);

  logic                   resv_valid_r, resv_valid_nxt;
  logic [31:0]            resv_addr_r, resv_addr_nxt;
  amo_result_t            obuf_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] owr_ptr_r, owr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] ord_ptr_r, ord_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                   obuf_space, do_out_pop;
  logic                   sc_ok;
  logic [31:0]            alu_val;
  amo_result_t            res;

  assign obuf_space = (ocnt_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign item_pop   = item_valid && obuf_space;
  assign out_empty  = (ocnt_r == '0);
  assign do_out_pop = out_pop && !out_empty;
  assign result     = obuf_r[ord_ptr_r];

  assign sc_ok = resv_valid_r && (resv_addr_r == item.addr);

  // Read-modify-write combine
  always_comb begin
    unique case (item.funct5)
      F5_SWAP: alu_val = item.opnd;
      F5_ADD:  alu_val = item.mem + item.opnd;
      F5_XOR:  alu_val = item.mem ^ item.opnd;
      F5_AND:  alu_val = item.mem & item.opnd;
      F5_OR:   alu_val = item.mem | item.opnd;
      F5_MIN:  alu_val = ($signed(item.mem) < $signed(item.opnd)) ? item.mem : item.opnd;
      F5_MAX:  alu_val = ($signed(item.mem) < $signed(item.opnd)) ? item.opnd : item.mem;
      F5_MINU: alu_val = (item.mem < item.opnd) ? item.mem : item.opnd;
      F5_MAXU: alu_val = (item.mem < item.opnd) ? item.opnd : item.mem;
      default: alu_val = item.opnd;
    endcase
  end

  // Result assembly; only non-NOP classes carry cause OK with side effects
  always_comb begin
    res.cause         = item.cause;
    res.dest_index    = item.rd;
    res.store_address = item.addr;
    res.dest_write    = (item.kind != KIND_NOP) && (item.rd != 5'd0);
    res.store_enable  = (item.kind == KIND_RMW) || ((item.kind == KIND_SC) && sc_ok);
    res.dest_data     = (item.kind == KIND_SC) ? {31'd0, !sc_ok} : item.mem;
    res.store_data    = (item.kind == KIND_SC) ? item.opnd : alu_val;
    if (!res.dest_write) begin
      res.dest_data = '0;
    end
    if (!res.store_enable) begin
      res.store_data = '0;
    end
  end

  // Reservation update, in program order
  always_comb begin
    resv_valid_nxt = resv_valid_r;
    resv_addr_nxt  = resv_addr_r;
    if (item_pop && (item.kind == KIND_LR)) begin
      resv_valid_nxt = 1'b1;
      resv_addr_nxt  = item.addr;
    end else if (item_pop && (item.kind == KIND_SC)) begin
      resv_valid_nxt = 1'b0;
    end
  end

  // Output buffer pointers
  always_comb begin
    owr_ptr_nxt = owr_ptr_r;
    ord_ptr_nxt = ord_ptr_r;
    ocnt_nxt    = ocnt_r;
    if (item_pop) begin
      owr_ptr_nxt = (owr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : owr_ptr_r + 1'b1;
    end
    if (do_out_pop) begin
      ord_ptr_nxt = (ord_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ord_ptr_r + 1'b1;
    end
    if (item_pop && !do_out_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (do_out_pop && !item_pop) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resv_valid_r <= 1'b0;
      resv_addr_r  <= '0;
      owr_ptr_r    <= '0;
      ord_ptr_r    <= '0;
      ocnt_r       <= '0;
    end else begin
      resv_valid_r <= resv_valid_nxt;
      resv_addr_r  <= resv_addr_nxt;
      owr_ptr_r    <= owr_ptr_nxt;
      ord_ptr_r    <= ord_ptr_nxt;
      ocnt_r       <= ocnt_nxt;
    end
  end

  // Result storage, no reset
  always_ff @(posedge clk) begin
    if (item_pop) begin
      obuf_r[owr_ptr_r] <= res;
    end
  end

endmodule

// ===== design/atomic_memory_op_unit.sv =====
// Atomic memory operation unit: RV32A word AMOs, LR/SC and MISC-MEM.
// An input is registered in the decoupling queue, then its result in the output
// buffer that drives the out_ ports. Throughput: one transaction per cycle
// sustained while results are popped; 2-entry queues on both sides.
// Reset: rst_n synchronous, active low; clears both queues and the reservation.
// Depends on amo_pkg, amo_front, amo_queue, amo_back.
module atomic_memory_op_unit import amo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_base_value,
  input  logic [31:0] in_operand_value,
  input  logic [31:0] in_memory_word,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_cause,
  output logic        out_dest_write,
  output logic [4:0]  out_dest_index,
  output logic [31:0] out_dest_data,
  output logic        out_store_enable,
  output logic [31:0] out_store_address,
  output logic [31:0] out_store_data
);

  amo_item_t   front_item;
  amo_item_t   back_item;
  logic        q_empty;
  logic        q_pop;
  amo_result_t result;

  // Decode
  amo_front u_front (
    .instruction   (in_instruction),
    .base_value    (in_base_value),
    .operand_value (in_operand_value),
    .memory_word   (in_memory_word),
    .item          (front_item)
  );

  // Decoupling queue
  amo_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .push_item (front_item),
    .empty     (q_empty),
    .pop       (q_pop),
    .pop_item  (back_item)
  );

  // Execute
  amo_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_empty),
    .item       (back_item),
    .item_pop   (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .result     (result)
  );

  assign out_cause         = result.cause;
  assign out_dest_write    = result.dest_write;
  assign out_dest_index    = result.dest_index;
  assign out_dest_data     = result.dest_data;
  assign out_store_enable  = result.store_enable;
  assign out_store_address = result.store_address;
  assign out_store_data    = result.store_data;

endmodule

// ===== design/amo_checker.sv =====
// Port-level checks for atomic_memory_op_unit, attached by bind.
// Depends on amo_pkg and atomic_memory_op_unit.
module amo_checker import amo_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_cause,
  input logic        out_dest_write,
  input logic [4:0]  out_dest_index,
  input logic [31:0] out_dest_data,
  input logic        out_store_enable,
  input logic [31:0] out_store_data
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A register write needs cause OK and a nonzero rd
  a_rd_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_dest_write) |-> (out_cause == CAUSE_OK && out_dest_index != 5'd0))
    else $error("rd write with error cause or rd zero");

  // A memory write needs cause OK
  a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_store_enable) |-> (out_cause == CAUSE_OK))
    else $error("memory write with error cause");

  // Unused data fields read as zero
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_dest_write || out_dest_data == '0) &&
                    (out_store_enable || out_store_data == '0)))
    else $error("data present without its write enable");

  // A waiting result stays, with its rd data unchanged, until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_dest_data)))
    else $error("waiting result changed before pop");

endmodule

bind atomic_memory_op_unit amo_checker u_amo_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_cause        (out_cause),
  .out_dest_write   (out_dest_write),
  .out_dest_index   (out_dest_index),
  .out_dest_data    (out_dest_data),
  .out_store_enable (out_store_enable),
  .out_store_data   (out_store_data)
);
